// ===== src/ppm_pkg.sv =====
// ============================================================================
// ppm_pkg
// Shared types and constants of the phrase position matcher.
// ============================================================================
package ppm_pkg;

  localparam int unsigned MAX_TERMS_DEF = 8;
  localparam int unsigned MAX_HITS_DEF  = 32;

  localparam int unsigned ELEM_W       = 32;
  localparam int unsigned POS_W        = 32;
  localparam int unsigned TERM_IDX_W   = 3;
  localparam int unsigned TERM_COUNT_W = 4;
  localparam int unsigned OCC_W        = 6;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TERM_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EMIT_POSITIONS = 2'd1;

  // Input opcodes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // Result kinds.
  localparam logic KIND_OCCURRENCE = 1'b0;
  localparam logic KIND_SUMMARY    = 1'b1;

  typedef struct packed {
    logic                  opcode;
    logic [TERM_IDX_W-1:0] term_index;
    logic [ELEM_W-1:0]     hit_element;
    logic [POS_W-1:0]      hit_position;
  } ppm_in_t;

  typedef struct packed {
    logic             kind;
    logic [ELEM_W-1:0] match_element;
    logic [POS_W-1:0]  match_start;
    logic             phrase_found;
    logic [OCC_W-1:0] occurrence_count;
    logic             overflowed;
    logic             last;
  } ppm_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;          // store the accepted hit
    logic init;          // start an evaluation
    logic rd_anchor;     // read term-0 entry at the anchor cursor
    logic latch_anchor;  // capture the anchor and restart the term walk
    logic rd_term;       // read the entry of the current term at the scan cursor
    logic term_next;     // current term satisfied, go on to the next term
    logic scan_next;     // advance the scan cursor within the current term
    logic occur;         // anchor matched: count it and emit if enabled
    logic anchor_next;   // advance to the next anchor
    logic summary;       // emit the summary and clear the counts and overflow flag
  } ppm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic anchor_done;   // all term-0 hits visited
    logic term_done;     // all phrase terms satisfied
    logic scan_done;     // current term list exhausted
    logic hit;           // read entry equals the wanted hit
  } ppm_sts_t;

endpackage

// ===== src/ppm_ctrl.sv =====
// ============================================================================
// ppm_ctrl
// Controller that sequences loads, the anchor walk and the term scans.
// ============================================================================
module ppm_ctrl
  import ppm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     opcode_i,
  input  ppm_sts_t sts_i,
  output ppm_cmd_t cmd_o,
  output logic     busy_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_A_RD,
    ST_A_LAT,
    ST_S_RD,
    ST_S_CMP,
    ST_SUM
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (opcode_i == OP_EVAL) begin
            cmd_o.init = 1'b1;
            state_d    = ST_A_RD;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_A_RD: begin
        if (sts_i.anchor_done) begin
          state_d = ST_SUM;
        end else begin
          cmd_o.rd_anchor = 1'b1;
          state_d         = ST_A_LAT;
        end
      end
      ST_A_LAT: begin
        cmd_o.latch_anchor = 1'b1;
        state_d            = ST_S_RD;
      end
      ST_S_RD: begin
        if (sts_i.term_done) begin
          cmd_o.occur       = 1'b1;
          cmd_o.anchor_next = 1'b1;
          state_d           = ST_A_RD;
        end else if (sts_i.scan_done) begin
          cmd_o.anchor_next = 1'b1;
          state_d           = ST_A_RD;
        end else begin
          cmd_o.rd_term = 1'b1;
          state_d       = ST_S_CMP;
        end
      end
      ST_S_CMP: begin
        if (sts_i.hit) begin
          cmd_o.term_next = 1'b1;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
        state_d = ST_S_RD;
      end
      ST_SUM: begin
        cmd_o.summary = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// ===== src/ppm_datapath.sv =====
// ============================================================================
// ppm_datapath
// Hit store, per-term counts, cursors, hit compare and the result register.
// ============================================================================
module ppm_datapath
  import ppm_pkg::*;
#(
  parameter int unsigned MAX_TERMS = MAX_TERMS_DEF,
  parameter int unsigned MAX_HITS  = MAX_HITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ppm_in_t               in_i,
  input  ppm_cmd_t              cmd_i,
  output ppm_sts_t              sts_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  res_valid_o,
  output ppm_out_t              res_o
);

  localparam int unsigned TW    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned HW    = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
  localparam int unsigned IW    = $clog2(MAX_TERMS + 1);
  localparam int unsigned CW    = $clog2(MAX_HITS + 1);
  localparam int unsigned AW    = TW + HW;
  localparam int unsigned DEPTH = 2 ** AW;
  localparam int unsigned ENT_W = ELEM_W + POS_W;

  // Configuration registers.
  logic [TERM_COUNT_W-1:0] term_count_q;
  logic                    emit_q;

  // Hit store memory: one write and one registered read per cycle.
  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] rdata_q;
  logic [AW-1:0]    waddr, raddr;
  logic             we;

  // Per-term fill counts and evaluation cursors.
  logic [CW-1:0]    counts_q [MAX_TERMS];
  logic             ovf_q;
  logic [CW-1:0]    a_q, j_q;
  logic [IW-1:0]    i_q, terms_q, terms_eff;
  logic [ELEM_W-1:0] anc_el_q;
  logic [POS_W-1:0]  anc_pos_q;
  logic [OCC_W-1:0] occ_q;
  logic             found_q;

  logic             term_ok;
  logic [TW-1:0]    wt;
  logic [CW-1:0]    cnt_sel;
  logic [POS_W:0]   want_pos;

  ppm_out_t         res_q, res_d;
  logic             res_valid_q, res_valid_d;

  assign wt      = TW'(in_i.term_index);
  assign term_ok = (int'(in_i.term_index) < int'(MAX_TERMS));
  assign we      = cmd_i.load && term_ok && (counts_q[wt] < CW'(MAX_HITS));
  assign waddr   = {wt, counts_q[wt][HW-1:0]};
  assign raddr   = cmd_i.rd_anchor ? {TW'(0), a_q[HW-1:0]}
                                   : {i_q[TW-1:0], j_q[HW-1:0]};

  // The read register only loads on an anchor or a term read, so the entry
  // it holds stays put until the controller has used it.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= {in_i.hit_element, in_i.hit_position};
    end
    if (cmd_i.rd_anchor || cmd_i.rd_term) begin
      rdata_q <= mem[raddr];
    end
  end

  // Effective term count, clamped to one .. MAX_TERMS.
  always_comb begin
    if (term_count_q == '0) begin
      terms_eff = IW'(1);
    end else if (int'(term_count_q) > int'(MAX_TERMS)) begin
      terms_eff = IW'(MAX_TERMS);
    end else begin
      terms_eff = IW'(term_count_q);
    end
  end

  assign cnt_sel  = (int'(i_q) < int'(MAX_TERMS)) ? counts_q[i_q[TW-1:0]] : '0;
  assign want_pos = {1'b0, anc_pos_q} + (POS_W+1)'(i_q);

  assign sts_o.anchor_done = (a_q >= counts_q[0]);
  assign sts_o.term_done   = (i_q >= terms_q);
  assign sts_o.scan_done   = (j_q >= cnt_sel);
  assign sts_o.hit         = (rdata_q[ENT_W-1:POS_W] == anc_el_q)
                          && ({1'b0, rdata_q[POS_W-1:0]} == want_pos);

  always_comb begin
    res_d       = res_q;
    res_valid_d = 1'b0;
    if (cmd_i.occur && emit_q) begin
      res_valid_d            = 1'b1;
      res_d.kind             = KIND_OCCURRENCE;
      res_d.match_element    = anc_el_q;
      res_d.match_start      = anc_pos_q;
      res_d.phrase_found     = 1'b0;
      res_d.occurrence_count = '0;
      res_d.overflowed       = 1'b0;
      res_d.last             = 1'b0;
    end else if (cmd_i.summary) begin
      res_valid_d            = 1'b1;
      res_d.kind             = KIND_SUMMARY;
      res_d.match_element    = '0;
      res_d.match_start      = '0;
      res_d.phrase_found     = (terms_q == IW'(1)) || found_q;
      res_d.occurrence_count = occ_q;
      res_d.overflowed       = ovf_q;
      res_d.last             = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (cmd_i.latch_anchor) begin
      anc_el_q  <= rdata_q[ENT_W-1:POS_W];
      anc_pos_q <= rdata_q[POS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_count_q <= TERM_COUNT_W'(1);
      emit_q       <= 1'b1;
      for (int t = 0; t < int'(MAX_TERMS); t++) begin
        counts_q[t] <= '0;
      end
      ovf_q       <= 1'b0;
      a_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      terms_q     <= IW'(1);
      occ_q       <= '0;
      found_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TERM_COUNT:     term_count_q <= cfg_data_i[TERM_COUNT_W-1:0];
          CFG_EMIT_POSITIONS: emit_q       <= cfg_data_i[0];
          default:            ;
        endcase
      end
      if (cmd_i.load && term_ok) begin
        if (we) begin
          counts_q[wt] <= counts_q[wt] + CW'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.init) begin
        a_q     <= '0;
        terms_q <= terms_eff;
        occ_q   <= '0;
        found_q <= 1'b0;
      end
      if (cmd_i.latch_anchor) begin
        i_q <= IW'(1);
        j_q <= '0;
      end
      if (cmd_i.term_next) begin
        i_q <= i_q + IW'(1);
        j_q <= '0;
      end
      if (cmd_i.scan_next) begin
        j_q <= j_q + CW'(1);
      end
      if (cmd_i.occur) begin
        occ_q   <= occ_q + OCC_W'(1);
        found_q <= 1'b1;
      end
      if (cmd_i.anchor_next) begin
        a_q <= a_q + CW'(1);
      end
      if (cmd_i.summary) begin
        for (int t = 0; t < int'(MAX_TERMS); t++) begin
          counts_q[t] <= '0;
        end
        ovf_q <= 1'b0;
        a_q   <= '0;
        i_q   <= '0;
        j_q   <= '0;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== src/phrase_position_matcher.sv =====
// ============================================================================
// phrase_position_matcher
// Positional phrase match over the hits of one document.
// ============================================================================
// Results leave on res_o for exactly one cycle, marked by res_valid_o, and
// the receiver cannot stall them, so it must take every strobed transaction.
// A load (opcode 0) is accepted when start_i is high and busy_o is low;
// busy_o stays low, so hits can stream in every cycle. An evaluate
// (opcode 1) raises busy_o until the summary has been issued. It compares
// the stored entries one at a time through the single read port of the hit
// store, whose read is registered. The summary result, always last,
// appears in the same cycle that busy_o falls.
//
// Each term keeps up to MAX_HITS hits in its own region of the hit store.
// For every term-0 hit, in load order, the controller scans the list of each
// further term for the hit at the same element and the position plus the
// term offset; the sum is formed one bit wider, so positions never wrap.
// A term whose list is full drops further hits and sets the overflow flag
// reported in the summary. The summary clears the counts and the flag; the
// store contents themselves are left alone, since only filled entries are
// ever read.
//
// The configuration port is always ready. Register 0 sets the term count
// (zero acts as one, values above MAX_TERMS act as MAX_TERMS), register 1
// enables one result per matched occurrence. Writes are meant to happen
// while the block is idle.
// ============================================================================
module phrase_position_matcher
  import ppm_pkg::*;
#(
  parameter int unsigned MAX_TERMS = MAX_TERMS_DEF,
  parameter int unsigned MAX_HITS  = MAX_HITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  ppm_in_t               in_i,
  output logic                  res_valid_o,
  output ppm_out_t              res_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  ppm_cmd_t cmd;
  ppm_sts_t sts;
  logic     busy;

  // Configuration writes are taken in any cycle.
  assign cfg_ready_o = 1'b1;

  ppm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .opcode_i (in_i.opcode),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  ppm_datapath #(
    .MAX_TERMS (MAX_TERMS),
    .MAX_HITS  (MAX_HITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  assign busy_o = busy;

endmodule
